// ===== rtl/transposition_table_probe_store_defines.svh =====
// ----------------------------------------------------------------------------
// transposition table probe store: assertion macros
// shared concurrent assertion forms, clocked on i_clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH

// consequent in the same cycle
`define TTPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ttps assertion failed");

// consequent in the cycle after the antecedent
`define TTPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ttps assertion failed");

`endif

// ===== rtl/ttps_pkg.sv =====
// ----------------------------------------------------------------------------
// ttps_pkg
// types and codes shared by the table controller and datapath
// ----------------------------------------------------------------------------
package ttps_pkg;

    localparam int KEY_W    = 64;
    localparam int DEPTH_W  = 6;
    localparam int BOUND_W  = 2;
    localparam int STATUS_W = 2;

    localparam logic REQ_PROBE = 1'b0;
    localparam logic REQ_STORE = 1'b1;

    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEPTH_LOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS      = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_EVAL,
        S_DONE,
        S_STORE
    } t_ctrl_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic read;
        logic eval;
        logic write;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic in_store;
        logic clr_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/ttps_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttps_ctrl
// sequencer: clearing pass after reset, then one request at a time
// ----------------------------------------------------------------------------
module ttps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ttps_pkg::t_dp_status i_st,
    output logic                o_in_ready,
    output ttps_pkg::t_dp_cmd   o_cmd
);
    import ttps_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_st.in_store ? S_STORE : S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.read = 1'b1;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_STORE: begin
                o_cmd.write = 1'b1;
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/ttps_dp.sv =====
// ----------------------------------------------------------------------------
// ttps_dp
// entry memory, request latch, hit and bound evaluation, output register
// ----------------------------------------------------------------------------
`include "transposition_table_probe_store_defines.svh"

module ttps_dp #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int MOVE_BITS     = 16,
    parameter int SCORE_BITS    = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ttps_pkg::t_dp_cmd                    i_cmd,
    output ttps_pkg::t_dp_status                 o_st,
    input  logic                                 i_req_type,
    input  logic [ttps_pkg::KEY_W-1:0]           i_pos_key,
    input  logic [ttps_pkg::DEPTH_W-1:0]         i_search_depth,
    input  logic signed [SCORE_BITS-1:0]         i_score_in,
    input  logic [ttps_pkg::BOUND_W-1:0]         i_bound_kind,
    input  logic [MOVE_BITS-1:0]                 i_move_in,
    input  logic signed [SCORE_BITS-1:0]         i_alpha_in,
    input  logic signed [SCORE_BITS-1:0]         i_beta_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [ttps_pkg::STATUS_W-1:0]        o_status,
    output logic signed [SCORE_BITS-1:0]         o_score_out,
    output logic signed [SCORE_BITS-1:0]         o_alpha_out,
    output logic signed [SCORE_BITS-1:0]         o_beta_out,
    output logic [MOVE_BITS-1:0]                 o_move_out,
    output logic                                 o_move_valid
);
    import ttps_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [DEPTH_W-1:0]    depth;
        logic [SCORE_BITS-1:0] score;
        logic [BOUND_W-1:0]    bound;
        logic [MOVE_BITS-1:0]  move;
    } t_row;

    t_row r_mem [TABLE_ENTRIES];
    t_row r_rd_row;

    logic [IDX_W-1:0] r_clr_idx;

    // latched request
    logic                         r_req_type;
    logic [KEY_W-1:0]             r_key;
    logic [DEPTH_W-1:0]           r_depth;
    logic signed [SCORE_BITS-1:0] r_score;
    logic [BOUND_W-1:0]           r_bound;
    logic [MOVE_BITS-1:0]         r_move;
    logic signed [SCORE_BITS-1:0] r_alpha;
    logic signed [SCORE_BITS-1:0] r_beta;

    // evaluation stage
    logic                         r_hit;
    logic                         r_depth_low;
    logic                         r_exact;
    logic signed [SCORE_BITS-1:0] r_score_e;
    logic [MOVE_BITS-1:0]         r_move_e;
    logic signed [SCORE_BITS-1:0] r_alpha_adj;
    logic signed [SCORE_BITS-1:0] r_beta_adj;

    logic                         n_hit;
    logic                         n_depth_low;
    logic                         use_lower;
    logic                         use_upper;
    logic signed [SCORE_BITS-1:0] rd_score;
    logic signed [SCORE_BITS-1:0] n_alpha_adj;
    logic signed [SCORE_BITS-1:0] n_beta_adj;

    logic                         we;
    logic [IDX_W-1:0]             waddr;
    t_row                         wrow;

    logic                         closed;
    logic [STATUS_W-1:0]          n_status;
    logic signed [SCORE_BITS-1:0] n_score_out;
    logic signed [SCORE_BITS-1:0] n_alpha_out;
    logic signed [SCORE_BITS-1:0] n_beta_out;
    logic [MOVE_BITS-1:0]         n_move_out;
    logic                         n_move_valid;

    logic r_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || i_out_ready;

    assign o_st.in_store = (i_req_type == REQ_STORE);
    assign o_st.clr_last = &r_clr_idx;
    assign o_st.out_free = out_free;

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type <= i_req_type;
            r_key      <= i_pos_key;
            r_depth    <= i_search_depth;
            r_score    <= i_score_in;
            r_bound    <= i_bound_kind;
            r_move     <= i_move_in;
            r_alpha    <= i_alpha_in;
            r_beta     <= i_beta_in;
        end
    end

    // memory write: zero rows while clearing, else a store of nonzero depth
    always_comb begin
        if (i_cmd.clear) begin
            we    = 1'b1;
            waddr = r_clr_idx;
            wrow  = '0;
        end else begin
            we    = i_cmd.write && (r_depth != '0);
            waddr = r_key[IDX_W-1:0];
            wrow  = '{key: r_key, depth: r_depth, score: r_score,
                      bound: r_bound, move: r_move};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wrow;
        end
        if (i_cmd.read) begin
            r_rd_row <= r_mem[r_key[IDX_W-1:0]];
        end
    end

    // hit test and window adjustment
    always_comb begin
        rd_score    = r_rd_row.score;
        n_hit       = (r_rd_row.depth != '0) && (r_rd_row.key == r_key);
        n_depth_low = r_rd_row.depth < r_depth;
        use_lower   = n_hit && !n_depth_low && (r_rd_row.bound == BOUND_LOWER)
                      && (rd_score > r_alpha);
        use_upper   = n_hit && !n_depth_low && (r_rd_row.bound == BOUND_UPPER)
                      && (rd_score < r_beta);
        n_alpha_adj = use_lower ? rd_score : r_alpha;
        n_beta_adj  = use_upper ? rd_score : r_beta;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_hit       <= n_hit;
            r_depth_low <= n_depth_low;
            r_exact     <= (r_rd_row.bound == BOUND_EXACT);
            r_score_e   <= rd_score;
            r_move_e    <= r_rd_row.move;
            r_alpha_adj <= n_alpha_adj;
            r_beta_adj  <= n_beta_adj;
        end
    end

    // result selection
    always_comb begin
        closed       = r_alpha_adj >= r_beta_adj;
        n_status     = ST_MISS;
        n_score_out  = '0;
        n_alpha_out  = r_alpha_adj;
        n_beta_out   = r_beta_adj;
        n_move_out   = '0;
        n_move_valid = 1'b0;
        if (r_req_type == REQ_STORE) begin
            n_status    = ST_DONE;
            n_alpha_out = '0;
            n_beta_out  = '0;
        end else if (r_hit) begin
            n_move_out   = r_move_e;
            n_move_valid = 1'b1;
            if (r_depth_low) begin
                n_status = ST_DEPTH_LOW;
            end else if (r_exact || closed) begin
                n_status    = ST_DONE;
                n_score_out = r_score_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status     <= n_status;
            o_score_out  <= n_score_out;
            o_alpha_out  <= n_alpha_out;
            o_beta_out   <= n_beta_out;
            o_move_out   <= n_move_out;
            o_move_valid <= n_move_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `TTPS_ASSERT_NOW(a_no_overwrite, i_cmd.load_out, out_free)
    `TTPS_ASSERT_NEXT(a_load_shows, i_cmd.load_out, o_out_valid)
    `TTPS_ASSERT_NOW(a_clear_excl, i_cmd.clear, !i_cmd.write && !i_cmd.accept)
    `TTPS_ASSERT_NOW(a_miss_no_move, o_out_valid && !o_move_valid, o_move_out == '0)
    `TTPS_ASSERT_NOW(a_score_only_done, o_out_valid && (o_status != ST_DONE), o_score_out == '0)

endmodule

// ===== rtl/transposition_table_probe_store.sv =====
// ----------------------------------------------------------------------------
// transposition_table_probe_store
// direct-mapped, always-replace transposition table with probe and store
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready) carries one request item: a probe
//   (i_req_type 0) or a store (i_req_type 1). output channel (o_out_valid /
//   i_out_ready) returns exactly one result item per request, in order.
//   the entry is selected by the low log2(TABLE_ENTRIES) bits of i_pos_key.
//   a probe passes through memory read, evaluation and output load after
//   acceptance, a store through memory write and output load.
//   one request is in work at a time and the sequencer goes back to idle
//   before taking the next, so a new request is accepted only once the last
//   result is loaded into the output register.
//   after reset a clearing pass writes every entry to zero, during which
//   o_in_ready stays low.
//   the result sits in an output register: a new request is accepted while
//   it waits, and if the receiver stalls the next result holds in the
//   block until the register frees, with o_in_ready low meanwhile.
// ----------------------------------------------------------------------------
module transposition_table_probe_store #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int MOVE_BITS     = 16,
    parameter int SCORE_BITS    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [ttps_pkg::KEY_W-1:0]    i_pos_key,
    input  logic [ttps_pkg::DEPTH_W-1:0]  i_search_depth,
    input  logic signed [SCORE_BITS-1:0]  i_score_in,
    input  logic [ttps_pkg::BOUND_W-1:0]  i_bound_kind,
    input  logic [MOVE_BITS-1:0]          i_move_in,
    input  logic signed [SCORE_BITS-1:0]  i_alpha_in,
    input  logic signed [SCORE_BITS-1:0]  i_beta_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ttps_pkg::STATUS_W-1:0] o_status,
    output logic signed [SCORE_BITS-1:0]  o_score_out,
    output logic signed [SCORE_BITS-1:0]  o_alpha_out,
    output logic signed [SCORE_BITS-1:0]  o_beta_out,
    output logic [MOVE_BITS-1:0]          o_move_out,
    output logic                          o_move_valid
);
    import ttps_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status st;

    ttps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (st),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    ttps_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MOVE_BITS     (MOVE_BITS),
        .SCORE_BITS    (SCORE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_req_type     (i_req_type),
        .i_pos_key      (i_pos_key),
        .i_search_depth (i_search_depth),
        .i_score_in     (i_score_in),
        .i_bound_kind   (i_bound_kind),
        .i_move_in      (i_move_in),
        .i_alpha_in     (i_alpha_in),
        .i_beta_in      (i_beta_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_score_out    (o_score_out),
        .o_alpha_out    (o_alpha_out),
        .o_beta_out     (o_beta_out),
        .o_move_out     (o_move_out),
        .o_move_valid   (o_move_valid)
    );

endmodule

// ===== bench/transposition_table_probe_store_tb.sv =====
// ----------------------------------------------------------------------------
// transposition_table_probe_store_tb
// checks probe and store answers against a table model kept in the bench;
// directed corner items first, then random sequences whose probes mostly use
// keys stored earlier, under random idling, a long output hold-off and drains
// ----------------------------------------------------------------------------
module transposition_table_probe_store_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ttps_pkg::*;

    localparam int TT_ENTRIES  = 1024;
    localparam int IDX_W       = $clog2(TT_ENTRIES);
    localparam int STALL_LIMIT = 4000;
    localparam int POOL_MAX    = 48;
    localparam int PRINT_MAX   = 100;

    localparam logic [BOUND_W-1:0] BOUND_SPARE = 2'd3;

    typedef struct packed {
        logic                 req_type;
        logic [KEY_W-1:0]     pos_key;
        logic [DEPTH_W-1:0]   depth;
        logic [15:0]          score;
        logic [BOUND_W-1:0]   bound;
        logic [15:0]          move;
        logic [15:0]          alpha;
        logic [15:0]          beta;
    } t_tt_request;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [15:0]          score;
        logic [15:0]          alpha;
        logic [15:0]          beta;
        logic [15:0]          move;
        logic                 move_valid;
    } t_tt_answer;

    typedef struct packed {
        logic [KEY_W-1:0]     pos_key;
        logic [15:0]          score;
        logic [DEPTH_W-1:0]   depth;
    } t_stored_key;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_ready;
    logic                        i_req_type     = REQ_PROBE;
    logic [KEY_W-1:0]            i_pos_key      = '0;
    logic [DEPTH_W-1:0]          i_search_depth = '0;
    logic signed [15:0]          i_score_in     = '0;
    logic [BOUND_W-1:0]          i_bound_kind   = BOUND_EXACT;
    logic [15:0]                 i_move_in      = '0;
    logic signed [15:0]          i_alpha_in     = '0;
    logic signed [15:0]          i_beta_in      = '0;
    logic                        o_out_valid;
    logic                        i_out_ready    = 1'b0;
    logic [STATUS_W-1:0]         o_status;
    logic signed [15:0]          o_score_out;
    logic signed [15:0]          o_alpha_out;
    logic signed [15:0]          o_beta_out;
    logic [15:0]                 o_move_out;
    logic                        o_move_valid;

    t_tt_request pending_reqs[$];
    t_tt_answer  answers_due[$];
    t_stored_key key_pool[$];
    t_tt_request offer;

    logic [KEY_W-1:0]   slot_key   [TT_ENTRIES];
    logic [DEPTH_W-1:0] slot_depth [TT_ENTRIES];
    logic [15:0]        slot_score [TT_ENTRIES];
    logic [BOUND_W-1:0] slot_bound [TT_ENTRIES];
    logic [15:0]        slot_move  [TT_ENTRIES];

    int  send_idle_pct = 24;
    int  recv_idle_pct = 55;
    int  hold_left     = 0;
    int  mismatches    = 0;
    int  answers_seen  = 0;
    int  stall_cycles  = 0;
    bit  in_taken      = 1'b0;

    transposition_table_probe_store u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_pos_key      (i_pos_key),
        .i_search_depth (i_search_depth),
        .i_score_in     (i_score_in),
        .i_bound_kind   (i_bound_kind),
        .i_move_in      (i_move_in),
        .i_alpha_in     (i_alpha_in),
        .i_beta_in      (i_beta_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_score_out    (o_score_out),
        .o_alpha_out    (o_alpha_out),
        .o_beta_out     (o_beta_out),
        .o_move_out     (o_move_out),
        .o_move_valid   (o_move_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table update and answer for one accepted item
    function automatic t_tt_answer lookup_or_store(input t_tt_request r);
        t_tt_answer         ans;
        logic [IDX_W-1:0]   idx;
        logic signed [15:0] s;
        logic signed [15:0] a;
        logic signed [15:0] b;
        idx = r.pos_key[IDX_W-1:0];
        ans = '0;
        if (r.req_type == REQ_STORE) begin
            if (r.depth != '0) begin
                slot_key[idx]   = r.pos_key;
                slot_depth[idx] = r.depth;
                slot_score[idx] = r.score;
                slot_bound[idx] = r.bound;
                slot_move[idx]  = r.move;
            end
            ans.status = ST_DONE;
            return ans;
        end
        a = $signed(r.alpha);
        b = $signed(r.beta);
        ans.status = ST_MISS;
        if (slot_depth[idx] != '0 && slot_key[idx] == r.pos_key) begin
            s = $signed(slot_score[idx]);
            ans.move       = slot_move[idx];
            ans.move_valid = 1'b1;
            if (slot_depth[idx] < r.depth) begin
                ans.status = ST_DEPTH_LOW;
            end else if (slot_bound[idx] == BOUND_EXACT) begin
                ans.status = ST_DONE;
                ans.score  = s;
            end else begin
                if (slot_bound[idx] == BOUND_LOWER && s > a) begin
                    a = s;
                end else if (slot_bound[idx] == BOUND_UPPER && s < b) begin
                    b = s;
                end
                if (a >= b) begin
                    ans.status = ST_DONE;
                    ans.score  = s;
                end
            end
        end
        ans.alpha = a;
        ans.beta  = b;
        return ans;
    endfunction

    function automatic t_tt_request tt_req(input logic typ, input logic [KEY_W-1:0] key,
                                           input int depth, input int score,
                                           input logic [BOUND_W-1:0] bound, input int move,
                                           input int alpha, input int beta);
        t_tt_request r;
        r.req_type = typ;
        r.pos_key  = key;
        r.depth    = depth[DEPTH_W-1:0];
        r.score    = score[15:0];
        r.bound    = bound;
        r.move     = move[15:0];
        r.alpha    = alpha[15:0];
        r.beta     = beta[15:0];
        return r;
    endfunction

    function automatic logic [15:0] near_score(input logic [15:0] centre);
        int v;
        v = int'($signed(centre)) + int'($urandom_range(8)) - 4;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_tt_request random_req();
        t_tt_request r;
        t_stored_key p;
        int          pick;
        r.req_type = REQ_PROBE;
        r.pos_key  = {$urandom, $urandom};
        r.depth    = DEPTH_W'($urandom_range(63));
        r.score    = 16'($urandom);
        r.move     = 16'($urandom);
        r.alpha    = 16'($urandom);
        r.beta     = 16'($urandom);
        pick       = $urandom_range(9);
        r.bound    = (pick < 3) ? BOUND_EXACT : (pick < 6) ? BOUND_LOWER :
                     (pick < 9) ? BOUND_UPPER : BOUND_SPARE;
        if (key_pool.size() > 0) begin
            p = key_pool[$urandom_range(key_pool.size() - 1)];
        end else begin
            p = '0;
        end
        if ($urandom_range(99) < 40) begin
            r.req_type = REQ_STORE;
            pick = $urandom_range(99);
            if (key_pool.size() > 0 && pick < 30) begin
                r.pos_key = p.pos_key ^ (64'd1 << $urandom_range(KEY_W - 1, IDX_W));
            end else if (key_pool.size() > 0 && pick < 50) begin
                r.pos_key = p.pos_key;
            end
            if ($urandom_range(99) < 8) begin
                r.depth = '0;
            end else begin
                r.depth = DEPTH_W'($urandom_range(63, 1));
            end
            case ($urandom_range(19))
                0: r.score = 16'h8000;
                1: r.score = 16'h7fff;
                2: r.score = 16'h0000;
                3: r.score = 16'hffff;
                default: ;
            endcase
            if (r.depth != '0) begin
                key_pool.push_back('{pos_key: r.pos_key, score: r.score, depth: r.depth});
                if (key_pool.size() > POOL_MAX) begin
                    void'(key_pool.pop_front());
                end
            end
        end else if (key_pool.size() > 0 && $urandom_range(99) < 75) begin
            r.pos_key = p.pos_key;
            if ($urandom_range(99) < 10) begin
                r.pos_key = p.pos_key ^ (64'd1 << $urandom_range(KEY_W - 1, IDX_W));
            end
            if ($urandom_range(99) < 70) begin
                r.depth = DEPTH_W'($urandom_range(p.depth));
            end
            if ($urandom_range(99) < 60) begin
                r.alpha = near_score(p.score);
                r.beta  = near_score(p.score);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_MAX) begin
            $display("mismatch at answer %0d: %s", answers_seen, what);
        end
        mismatches++;
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || i_in_valid || answers_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic push_random(input int count);
        repeat (count) pending_reqs.push_back(random_req());
    endtask

    // sender: acceptance and prediction on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TT_ENTRIES; k++) begin
                slot_key[k]   = '0;
                slot_depth[k] = '0;
                slot_score[k] = '0;
                slot_bound[k] = BOUND_EXACT;
                slot_move[k]  = '0;
            end
            in_taken = 1'b0;
        end else begin
            in_taken = i_in_valid && o_in_ready;
            if (in_taken) begin
                answers_due.push_back(lookup_or_store(offer));
            end
        end
    end

    // sender: next item on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                offer           = pending_reqs.pop_front();
                i_req_type     <= offer.req_type;
                i_pos_key      <= offer.pos_key;
                i_search_depth <= offer.depth;
                i_score_in     <= offer.score;
                i_bound_kind   <= offer.bound;
                i_move_in      <= offer.move;
                i_alpha_in     <= offer.alpha;
                i_beta_in      <= offer.beta;
                i_in_valid     <= 1'b1;
            end else begin
                i_in_valid     <= 1'b0;
            end
        end
    end

    // receiver: ready on the falling edge, long hold-off counted here
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_tt_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answers_due.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                want = answers_due.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d", o_status, want.status));
                if (o_score_out !== want.score)
                    report_mismatch($sformatf("score %0d want %0d", o_score_out,
                                              $signed(want.score)));
                if (o_alpha_out !== want.alpha)
                    report_mismatch($sformatf("alpha %0d want %0d", o_alpha_out,
                                              $signed(want.alpha)));
                if (o_beta_out !== want.beta)
                    report_mismatch($sformatf("beta %0d want %0d", o_beta_out,
                                              $signed(want.beta)));
                if (o_move_out !== want.move)
                    report_mismatch($sformatf("move %h want %h", o_move_out, want.move));
                if (o_move_valid !== want.move_valid)
                    report_mismatch($sformatf("move_valid %b want %b", o_move_valid,
                                              want.move_valid));
            end
            answers_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0] k_full;
        logic [KEY_W-1:0] k_low;
        logic [KEY_W-1:0] k_lb;
        logic [KEY_W-1:0] k_ub;
        logic [KEY_W-1:0] k_sp;
        logic [KEY_W-1:0] k_alias;
        k_full  = 64'hffff_ffff_ffff_ffff;
        k_low   = 64'h0123_4567_89ab_c001;
        k_lb    = 64'ha5a5_0000_0000_0102;
        k_ub    = 64'h5a5a_ffff_0000_0203;
        k_sp    = 64'h0f0f_0f0f_0f0f_0304;
        k_alias = 64'ha5a4_0000_0000_0102;

        // empty entry and ignored zero-depth store
        pending_reqs.push_back(tt_req(REQ_PROBE, '0, 0, 0, BOUND_EXACT, 0, -32768, 32767));
        pending_reqs.push_back(tt_req(REQ_STORE, '0, 0, 123, BOUND_EXACT, 1, 0, 0));
        pending_reqs.push_back(tt_req(REQ_PROBE, '0, 0, 0, BOUND_EXACT, 0, 0, 0));
        // exact bound at the field extremes
        pending_reqs.push_back(tt_req(REQ_STORE, k_full, 63, 32767, BOUND_EXACT, 'hffff,
                                      32767, -32768));
        pending_reqs.push_back(tt_req(REQ_PROBE, k_full, 63, 0, BOUND_EXACT, 0, -32768, 32767));
        pending_reqs.push_back(tt_req(REQ_PROBE, k_full, 0, -1, BOUND_SPARE, 'hffff, 0, 0));
        // depth too low
        pending_reqs.push_back(tt_req(REQ_STORE, k_low, 1, -32768, BOUND_EXACT, 0, 0, 0));
        pending_reqs.push_back(tt_req(REQ_PROBE, k_low, 2, 0, BOUND_EXACT, 0, 5, 6));
        // lower bound: open, closed, no raise
        pending_reqs.push_back(tt_req(REQ_STORE, k_lb, 10, 100, BOUND_LOWER, 'h1234, 0, 0));
        pending_reqs.push_back(tt_req(REQ_PROBE, k_lb, 10, 0, BOUND_EXACT, 0, 50, 200));
        pending_reqs.push_back(tt_req(REQ_PROBE, k_lb, 5, 0, BOUND_EXACT, 0, 50, 100));
        pending_reqs.push_back(tt_req(REQ_PROBE, k_lb, 5, 0, BOUND_EXACT, 0, 150, 200));
        // upper bound: closed then open
        pending_reqs.push_back(tt_req(REQ_STORE, k_ub, 20, -32768, BOUND_UPPER, 'hbeef, 0, 0));
        pending_reqs.push_back(tt_req(REQ_PROBE, k_ub, 20, 0, BOUND_EXACT, 0, -32768, 0));
        pending_reqs.push_back(tt_req(REQ_STORE, k_ub, 20, 0, BOUND_UPPER, 'h00ff, 0, 0));
        pending_reqs.push_back(tt_req(REQ_PROBE, k_ub, 1, 0, BOUND_EXACT, 0, -5, 10));
        // unnamed bound code: window test only
        pending_reqs.push_back(tt_req(REQ_STORE, k_sp, 7, 5, BOUND_SPARE, 'h5555, 0, 0));
        pending_reqs.push_back(tt_req(REQ_PROBE, k_sp, 7, 0, BOUND_EXACT, 0, 3, 3));
        pending_reqs.push_back(tt_req(REQ_PROBE, k_sp, 7, 0, BOUND_EXACT, 0, 1, 2));
        // same index, other key: miss, then replace
        pending_reqs.push_back(tt_req(REQ_PROBE, k_alias, 0, 0, BOUND_EXACT, 0, 0, 1));
        pending_reqs.push_back(tt_req(REQ_STORE, k_alias, 3, -1, BOUND_EXACT, 'haaaa, 0, 0));
        pending_reqs.push_back(tt_req(REQ_PROBE, k_lb, 0, 0, BOUND_EXACT, 0, 0, 1));
        // zero key once written
        pending_reqs.push_back(tt_req(REQ_STORE, '0, 5, 7, BOUND_EXACT, 'h0f0f, 0, 0));
        pending_reqs.push_back(tt_req(REQ_PROBE, '0, 5, 0, BOUND_EXACT, 0, 0, 0));
        pending_reqs.push_back(tt_req(REQ_PROBE, k_full, 63, 0, BOUND_EXACT, 0, 32767, -32768));

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        drain();
        push_random(300);
        while (pending_reqs.size() > 250) @(posedge i_clk);
        hold_left = 400;
        push_random(300);
        drain();

        send_idle_pct = 55;
        recv_idle_pct = 24;
        push_random(550);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(550);
        drain();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ttps_pkg.sv
rtl/ttps_ctrl.sv
rtl/ttps_dp.sv
rtl/transposition_table_probe_store.sv
bench/transposition_table_probe_store_tb.sv
